/* rtl/mps_pkg.sv */
// package: shared types and constants of the multi-policy process scheduler
`default_nettype none
package mps_pkg;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         slot_index;
        logic [2:0]         new_status;
        logic [5:0]         nice_value;
        logic signed [7:0]  priority_value;
        logic [31:0]        cpu_time;
        logic [31:0]        current_tick;
    } t_in_word;

    typedef struct packed {
        logic       decided;
        logic [5:0] next_slot;
        logic       switched;
        logic [6:0] ready_total;
        logic       no_tickets;
    } t_out_word;

    // slot entry as stored in the slot memory
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] credit;
        logic [5:0]  nice;
        logic [7:0]  prio;
        logic [31:0] cpu;
    } t_slot;

    localparam int SLOT_W = 65;

    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_READY  = 3'd1;
    localparam logic [2:0] ACT_RESUME = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_YIELD  = 3'd4;

    localparam logic [2:0] ST_UNUSED  = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_STOPPED = 3'd3;

    localparam logic [2:0] POL_AGING  = 3'd0;
    localparam logic [2:0] POL_PRIO   = 3'd1;
    localparam logic [2:0] POL_RR     = 3'd2;
    localparam logic [2:0] POL_RANDOM = 3'd3;
    localparam logic [2:0] POL_LOTTO  = 3'd4;

    localparam logic [1:0] CFG_POLICY  = 2'd0;
    localparam logic [1:0] CFG_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_UPRIO   = 2'd2;

    localparam logic [14:0] RANDOM_DRAW = 15'd16838;
    localparam int          TICKET_BASE = 140;

endpackage
`default_nettype wire

/* rtl/multi_policy_process_scheduler.sv */
// top level: slot table in memory, sequenced yield scans and policy choice
//
//  channel  | dir | handshake            | payload
//  in       | in  | i_in_valid/o_in_ready | t_in_word
//  out      | out | o_out_valid/i_out_ready| t_out_word
//  cfg      | in  | i_cfg_we              | i_cfg_index, i_cfg_data
//
// load, ready and resume: the slot is read (S_RD), modified and written (S_MOD), then the result is set in S_DONE
// a yield scans the table twice, first counting and then choosing, with a read and a use state a slot;
// random and lottery add a divider run for the remainder, lottery adds an aging scan,
// aging fifo adds a write-back state per new leader; round robin stops at the first ready slot
// one word in work at a time; the next is taken once the result register is free
// reset clears control and sets the config defaults; a clearing pass over every slot follows, no word taken
`default_nettype none
module multi_policy_process_scheduler #(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mps_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output mps_pkg::t_out_word     o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [9:0]        i_cfg_data
);
    import mps_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_RD     = 5'd2;
    localparam logic [4:0] S_MOD    = 5'd3;
    localparam logic [4:0] S_CUR_RD = 5'd4;
    localparam logic [4:0] S_CUR_WR = 5'd5;
    localparam logic [4:0] S_CNT_RD = 5'd6;
    localparam logic [4:0] S_CNT    = 5'd7;
    localparam logic [4:0] S_RMOD   = 5'd8;
    localparam logic [4:0] S_DIV    = 5'd9;
    localparam logic [4:0] S_CH_RD  = 5'd10;
    localparam logic [4:0] S_CH     = 5'd11;
    localparam logic [4:0] S_AG_RD  = 5'd12;
    localparam logic [4:0] S_AG     = 5'd13;
    localparam logic [4:0] S_WIN_RD = 5'd14;
    localparam logic [4:0] S_WIN_WR = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd16;
    localparam logic [4:0] S_AG_WR  = 5'd17;

    logic [4:0]    r_state;
    t_in_word      r_item;
    logic [2:0]    r_policy;
    logic [9:0]    r_quantum;
    logic [7:0]    r_uprio;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_prev;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_next;
    logic [AW-1:0] r_cand;
    logic [CW-1:0] r_nready;
    logic [CW-1:0] r_ord;
    logic signed [47:0] r_total;
    logic signed [47:0] r_start;
    logic [31:0]   r_ticket;
    logic          r_found;
    logic          r_nt;
    logic          r_wrap;
    t_slot         r_best;
    t_out_word     r_out;
    logic          r_out_valid;

    logic          w_we;
    logic [AW-1:0] w_addr;
    t_slot         w_wdata;
    t_slot         w_rdata;

    mps_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_div_rem;
    logic [31:0] w_div_num;
    logic [31:0] w_div_den;

    assign w_div_num = (r_policy == POL_RANDOM) ? 32'(RANDOM_DRAW) : r_item.current_tick;
    assign w_div_den = (r_policy == POL_RANDOM) ? 32'(r_nready) : r_total[31:0];

    mps_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    logic [15:0] w_aged;
    logic signed [47:0] w_tix;
    logic signed [47:0] w_end;
    logic [AW-1:0] w_rr_idx;
    logic          w_idx_ok;
    logic          w_outbid;

    function automatic logic [AW-1:0] w_rr_idx_cur(input logic [AW-1:0] cur);
        return (cur == LAST || cur == '0) ? AW'(1) : cur + AW'(1);
    endfunction

    assign w_aged = (w_rdata.credit == 16'hFFFF) ? w_rdata.credit : w_rdata.credit + 16'd1;
    assign w_tix  = 48'(TICKET_BASE) - 48'(signed'(w_rdata.prio)) - 48'(w_rdata.nice)
                    + 48'(w_rdata.credit);
    assign w_end  = r_start + w_tix;
    assign w_rr_idx = (r_idx == LAST) ? AW'(1) : r_idx + AW'(1);
    assign w_idx_ok = (7'(i_in_data.slot_index) < 7'(SLOT_COUNT)) || (SLOT_COUNT >= 64);
    assign w_outbid = (r_policy == POL_AGING) && (r_idx != '0)
                      && (w_rdata.status == ST_READY) && (w_rdata.credit > r_best.credit);

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_div_start = (r_state == S_RMOD)
                         && (((r_policy == POL_LOTTO) && (r_total > 0))
                             || ((r_policy == POL_RANDOM) && (r_nready != '0)));

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_idx;
        w_wdata = w_rdata;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_IDLE: w_addr = AW'(i_in_data.slot_index);
            S_RD:   w_addr = AW'(r_item.slot_index);
            S_MOD: begin
                w_addr = AW'(r_item.slot_index);
                unique case (r_item.action)
                    ACT_LOAD: begin
                        w_we    = 1'b1;
                        w_wdata = '{status: r_item.new_status, credit: 16'd0,
                                    nice: r_item.nice_value, prio: r_item.priority_value,
                                    cpu: r_item.cpu_time};
                    end
                    ACT_READY: begin
                        w_we           = 1'b1;
                        w_wdata.status = ST_READY;
                        w_wdata.credit = 16'd0;
                    end
                    ACT_RESUME: begin
                        w_we           = (w_rdata.status == ST_STOPPED);
                        w_wdata.status = ST_READY;
                        w_wdata.credit = 16'd0;
                    end
                    default: w_we = 1'b0;
                endcase
            end
            S_CUR_RD: w_addr = r_cur;
            S_CUR_WR: begin
                w_addr = r_cur;
                if (r_item.action == ACT_STOP) begin
                    w_we           = 1'b1;
                    w_wdata.status = ST_STOPPED;
                end else if (w_rdata.status == ST_RUNNING) begin
                    w_we           = 1'b1;
                    w_wdata.status = ST_READY;
                    w_wdata.credit = 16'd0;
                end
            end
            S_AG: begin
                if (w_rdata.status == ST_READY && r_idx != r_next) begin
                    w_we           = 1'b1;
                    w_wdata.credit = w_aged;
                end
            end
            S_AG_WR: begin
                // age the displaced aging-fifo candidate
                w_addr         = r_next;
                w_we           = 1'b1;
                w_wdata        = r_best;
                w_wdata.credit = (r_best.credit == 16'hFFFF) ? r_best.credit
                                 : r_best.credit + 16'd1;
            end
            S_CH: begin
                if (r_policy == POL_AGING && r_idx != '0 && w_rdata.status == ST_READY
                    && !(w_rdata.credit > r_best.credit)) begin
                    w_we           = 1'b1;
                    w_wdata.credit = w_aged;
                end
            end
            S_WIN_RD: w_addr = r_next;
            S_WIN_WR: begin
                w_addr         = r_next;
                w_we           = 1'b1;
                w_wdata.status = ST_RUNNING;
                w_wdata.credit = 16'(r_quantum);
                w_wdata.prio   = r_uprio;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_policy    <= 3'd3;
            r_quantum   <= 10'd50;
            r_uprio     <= 8'd40;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POLICY:  r_policy  <= i_cfg_data[2:0];
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    CFG_UPRIO:   r_uprio   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in_data;
                        r_out  <= '{decided: 1'b0, next_slot: 6'(r_cur), switched: 1'b0,
                                   ready_total: 7'd0, no_tickets: 1'b0};
                        r_prev <= r_cur;
                        if (i_in_data.action == ACT_STOP || i_in_data.action == ACT_YIELD) begin
                            r_state <= S_CUR_RD;
                        end else if (i_in_data.action <= ACT_RESUME && w_idx_ok) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RD:     r_state <= S_MOD;
                S_MOD:    r_state <= S_DONE;
                S_CUR_RD: r_state <= S_CUR_WR;
                S_CUR_WR: begin
                    r_idx    <= AW'(1);
                    r_total  <= '0;
                    r_nready <= '0;
                    r_state  <= S_CNT_RD;
                end
                S_CNT_RD: r_state <= S_CNT;
                S_CNT: begin
                    if (w_rdata.status != ST_UNUSED) begin
                        r_total <= r_total + w_tix;
                    end
                    if (w_rdata.status == ST_READY) begin
                        r_nready <= r_nready + CW'(1);
                    end
                    if (r_idx == LAST) begin
                        r_state <= S_RMOD;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_CNT_RD;
                    end
                end
                S_RMOD: begin
                    r_next  <= '0;
                    r_found <= 1'b0;
                    r_nt    <= (r_policy == POL_LOTTO) && !(r_total > 0);
                    r_ord   <= '0;
                    r_start <= '0;
                    r_best  <= '0;
                    r_wrap  <= 1'b0;
                    r_out.ready_total <= 7'(r_nready);
                    if (r_policy == POL_RR) begin
                        r_idx <= w_rr_idx_cur(r_cur);
                    end else if (r_policy == POL_AGING) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= AW'(1);
                    end
                    if (r_policy > POL_LOTTO) begin
                        r_state <= S_DONE;
                    end else if (w_div_start) begin
                        r_state <= S_DIV;
                    end else if (r_policy == POL_LOTTO || r_policy == POL_RANDOM) begin
                        r_state <= S_WIN_RD;
                    end else begin
                        r_state <= S_CH_RD;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ticket <= w_div_rem;
                        r_state  <= S_CH_RD;
                    end
                end
                S_CH_RD: r_state <= S_CH;
                S_CH: begin
                    unique case (r_policy)
                        POL_AGING: begin
                            if (r_idx == '0) begin
                                r_best <= w_rdata;
                            end else if (w_outbid) begin
                                r_cand <= r_idx;
                            end
                        end
                        POL_PRIO: begin
                            if (w_rdata.status == ST_READY && (!r_found
                                || w_rdata.nice < r_best.nice
                                || (w_rdata.nice == r_best.nice
                                    && w_rdata.cpu < r_best.cpu))) begin
                                r_best  <= w_rdata;
                                r_next  <= r_idx;
                                r_found <= 1'b1;
                            end
                        end
                        POL_RR: begin
                            if (w_rdata.status == ST_READY && !r_found) begin
                                r_next  <= r_idx;
                                r_found <= 1'b1;
                            end
                        end
                        POL_RANDOM: begin
                            if (w_rdata.status == ST_READY && !r_found) begin
                                if (32'(r_ord) == r_ticket) begin
                                    r_next  <= r_idx;
                                    r_found <= 1'b1;
                                end
                                r_ord <= r_ord + CW'(1);
                            end
                        end
                        default: begin
                            if (w_rdata.status == ST_READY) begin
                                r_start <= w_end;
                                if (!r_found && w_end > $signed({16'd0, r_ticket})) begin
                                    r_found <= 1'b1;
                                    r_next  <= r_idx;
                                end
                            end
                        end
                    endcase
                    if (r_policy == POL_RR) begin
                        r_idx <= w_rr_idx;
                        if (r_idx == r_cur || (r_cur == '0 && r_idx == LAST)
                            || r_found || (w_rdata.status == ST_READY)) begin
                            r_state <= S_WIN_RD;
                        end else begin
                            r_state <= S_CH_RD;
                        end
                    end else if (r_idx == LAST) begin
                        if (w_outbid) begin
                            r_state <= S_AG_WR;
                        end else begin
                            r_state <= (r_policy == POL_LOTTO) ? S_AG_RD : S_WIN_RD;
                        end
                        r_wrap <= 1'b1;
                        r_idx  <= AW'(1);
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= w_outbid ? S_AG_WR : S_CH_RD;
                    end
                end
                S_AG_WR: begin
                    r_next  <= r_cand;
                    r_best  <= w_rdata;
                    r_state <= r_wrap ? S_WIN_RD : S_CH_RD;
                end
                S_AG_RD: r_state <= S_AG;
                S_AG: begin
                    r_idx <= r_idx + AW'(1);
                    r_state <= (r_idx == LAST) ? S_WIN_RD : S_AG_RD;
                end
                S_WIN_RD: r_state <= S_WIN_WR;
                S_WIN_WR: begin
                    r_cur <= r_next;
                    r_out.decided    <= 1'b1;
                    r_out.next_slot  <= 6'(r_next);
                    r_out.switched   <= (r_next != r_prev);
                    r_out.no_tickets <= r_nt;
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < SLOT_COUNT)
        else $error("current slot out of range");
    a_win_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIN_WR) |=> (r_state == S_DONE))
        else $error("winner write not followed by result");
endmodule
`default_nettype wire

/* rtl/mps_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire

/* rtl/mps_divider.sv */
// restoring divider, one quotient bit per cycle, gives the remainder
`default_nettype none
module mps_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_rem
);
    logic [31:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_shift;
    logic [32:0] w_diff;

    assign w_shift = {r_rem[31:0], r_num[31]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_diff[32] ? w_shift : w_diff;
        end
    end

    assign o_rem = r_rem[31:0];
endmodule
`default_nettype wire
